@@ hdl/octave_value_noise_2d_core_macros.svh @@
// Assertion macros shared by the octave value noise core.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef OCTAVE_VALUE_NOISE_2D_CORE_MACROS_SVH
`define OCTAVE_VALUE_NOISE_2D_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ovn_pkg.sv @@
// Shared types and constants for the octave value noise core.
// No dependencies; the top level and the divider import this package.
package ovn_pkg;

  // Seed table geometry.
  localparam int SIDE_LOG2 = 8;
  localparam int COORD_W   = SIDE_LOG2;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int SEED_W    = 16;

  // Configuration registers.
  localparam int OCT_W  = 4;
  localparam int BIAS_W = 10;
  localparam logic [OCT_W-1:0]  OCT_RESET  = OCT_W'(1);
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(512);
  localparam logic [OCT_W-1:0]  MAX_OCT    = OCT_W'(SIDE_LOG2 + 1);
  localparam logic [OCT_W-1:0]  SHIFT_TOP  = OCT_W'(SIDE_LOG2);

  // Datapath widths.
  localparam int VAL_W  = SEED_W + 1;
  localparam int MULA_W = VAL_W + 1;
  localparam int W_W    = 32;
  localparam int MULB_W = W_W + 1;
  localparam int PROD_W = MULA_W + MULB_W;
  localparam int WSUM_W = W_W + 4;
  localparam int SUM_W  = 52;
  localparam logic [W_W-1:0] W_ONE = W_W'(65536);

  // Shared divider.
  localparam int DIV_NUM_W = SUM_W;
  localparam int DIV_DEN_W = WSUM_W;
  localparam int DIV_CNT_W = 6;
  localparam int WNUM_W    = W_W + 8;
  localparam logic [DIV_CNT_W-1:0] WDIV_ITERS = DIV_CNT_W'(WNUM_W);
  localparam logic [DIV_CNT_W-1:0] FDIV_ITERS = DIV_CNT_W'(DIV_NUM_W);

  // Operation codes carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_BIAS         = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_TOP,
    ST_MUL_BOT,
    ST_BOT,
    ST_MUL_VAL,
    ST_VAL,
    ST_MUL_W,
    ST_ACC,
    ST_WDIV,
    ST_WWAIT,
    ST_FDIV,
    ST_FWAIT,
    ST_PUSH
  } ovn_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/octave_value_noise_2d_core.sv @@
// Top level of the octave value noise core: sequencer, seed table and datapath.
// Depends on ovn_pkg, ovn_ram, ovn_div and the assertion macro header.
//
// Usage:
//   The input stream carries one item per transfer. tuser selects the operation:
//   a seed write stores seed_value at cell (x,y), an evaluate returns the
//   octave-summed bilinear value noise at pixel (x,y) on the output stream.
//   The configuration channel sets the octave count (index 0) and the weight
//   divisor bias (index 1); write it only while the core is idle.
// Sequence:
//   A seed write produces no output transfer.
//   An evaluate over n octaves does, per octave, four seed reads from the
//   single-port table and multiply steps for the top, bottom, interpolated and
//   weighted values, then a weight division on the shared divider between
//   octaves, and a final division of the weighted sum by the weight sum.
//   in_tready is high only while no evaluate is in progress.
// Reset and stall:
//   Reset returns the sequencer to idle, empties the output register and loads
//   octave_count = 1 and bias = 2.0. The seed table is not cleared: every cell
//   must be written before an evaluate reads it.
//   A finished result waits in the output register; a new item is accepted
//   while it waits, and the next result waits until the register is free.
`include "octave_value_noise_2d_core_macros.svh"

module octave_value_noise_2d_core
  import ovn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x [7:0], y [15:8], seed_value [31:16]
  input  logic [0:0]  in_tuser,   // operation [0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // noise [15:0]
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  ovn_state_t state_r, state_nxt;

  logic [OCT_W-1:0]  octave_count_r;
  logic [BIAS_W-1:0] bias_r;

  logic [COORD_W-1:0] px_r, px_nxt;
  logic [COORD_W-1:0] py_r, py_nxt;
  logic [OCT_W-1:0]   n_r, n_nxt;
  logic [OCT_W-1:0]   o_r, o_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [SEED_W-1:0] corner_r [4];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  top_r, top_nxt;
  logic signed [VAL_W-1:0]  bot_r, bot_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic [W_W-1:0]           w_r, w_nxt;
  logic [WSUM_W-1:0]        wsum_r, wsum_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SEED_W-1:0]        out_data_r, out_data_nxt;
  logic [SEED_W-1:0]        res_r, res_nxt;

  logic in_acc;
  logic [COORD_W-1:0] in_x, in_y;
  logic [SEED_W-1:0]  in_seed;
  logic [OCT_W-1:0]   n_clip;

  logic [COORD_W-1:0] mask, x0, x1, y0, y1, f, g;
  logic [OCT_W-1:0]   shamt;
  logic signed [PROD_W-1:0] shifted;
  logic signed [VAL_W-1:0]  lerp_part;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr, rd_addr;
  logic [SEED_W-1:0]  ram_rdata;

  div_cmd_t             div_cmd;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic [BIAS_W-1:0]    bias_eff;
  logic [DIV_NUM_W-1:0] sum_mag;

  // Unpack the input stream.
  assign in_x    = in_tdata[7:0];
  assign in_y    = in_tdata[15:8];
  assign in_seed = in_tdata[31:16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OCT_RESET;
      bias_r         <= BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OCTAVE_COUNT: octave_count_r <= cfg_data[OCT_W-1:0];
        REG_BIAS:         bias_r         <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Octave count clipped so the pitch stays at least one.
  always_comb begin
    if (octave_count_r == '0) begin
      n_clip = OCT_W'(1);
    end else if (octave_count_r > MAX_OCT) begin
      n_clip = MAX_OCT;
    end else begin
      n_clip = octave_count_r;
    end
  end

  // Cell geometry of the current octave; the pitch is mask + 1.
  always_comb begin
    mask  = {COORD_W{1'b1}} >> o_r;
    x0    = px_r & ~mask;
    y0    = py_r & ~mask;
    x1    = x0 + mask + COORD_W'(1);
    y1    = y0 + mask + COORD_W'(1);
    f     = px_r & mask;
    g     = py_r & mask;
    shamt = SHIFT_TOP - o_r;
  end

  // Corner address for the current read step.
  always_comb begin
    case (k_r[1:0])
      2'd0:    rd_addr = {y0, x0};
      2'd1:    rd_addr = {y0, x1};
      2'd2:    rd_addr = {y1, x0};
      2'd3:    rd_addr = {y1, x1};
      default: rd_addr = {y0, x0};
    endcase
  end

  assign ram_we   = in_acc && (in_tuser[0] == OP_WRITE);
  assign ram_addr = (state_r == ST_IDLE) ? {in_y, in_x} : rd_addr;

  ovn_ram #(
    .WIDTH (SEED_W),
    .DEPTH (DEPTH)
  ) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_seed),
    .rdata (ram_rdata)
  );

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_TOP: begin
        mul_a = MULA_W'(VAL_W'(corner_r[1]) - VAL_W'(corner_r[0]));
        mul_b = MULB_W'(f);
      end
      ST_MUL_BOT: begin
        mul_a = MULA_W'(VAL_W'(corner_r[3]) - VAL_W'(corner_r[2]));
        mul_b = MULB_W'(f);
      end
      ST_MUL_VAL: begin
        mul_a = MULA_W'(bot_r) - MULA_W'(top_r);
        mul_b = MULB_W'(g);
      end
      ST_MUL_W: begin
        mul_a = MULA_W'(val_r);
        mul_b = MULB_W'(w_r);
      end
      default: ;
    endcase
  end

  // Floor division of the last product by the pitch.
  assign shifted   = prod_r >>> shamt;
  assign lerp_part = shifted[VAL_W-1:0];

  // Divider operands.
  assign bias_eff = (bias_r == '0) ? BIAS_W'(1) : bias_r;
  assign sum_mag  = sum_r[SUM_W-1] ? DIV_NUM_W'(-sum_r) : DIV_NUM_W'(sum_r);

  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.iters = WDIV_ITERS;
    div_num       = {w_r, {(DIV_NUM_W - W_W){1'b0}}};
    div_den       = DIV_DEN_W'(bias_eff);
    if (state_r == ST_WDIV) begin
      div_cmd.start = 1'b1;
    end else if (state_r == ST_FDIV) begin
      div_cmd.start = 1'b1;
      div_cmd.iters = FDIV_ITERS;
      div_num       = sum_mag;
      div_den       = wsum_r;
    end
  end

  ovn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == OP_EVAL)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (k_r == 3'd4) begin
          state_nxt = ST_MUL_TOP;
        end
      end
      ST_MUL_TOP: state_nxt = ST_MUL_BOT;
      ST_MUL_BOT: state_nxt = ST_BOT;
      ST_BOT:     state_nxt = ST_MUL_VAL;
      ST_MUL_VAL: state_nxt = ST_VAL;
      ST_VAL:     state_nxt = ST_MUL_W;
      ST_MUL_W:   state_nxt = ST_ACC;
      ST_ACC: begin
        if ((o_r + OCT_W'(1)) < n_r) begin
          state_nxt = ST_WDIV;
        end else begin
          state_nxt = ST_FDIV;
        end
      end
      ST_WDIV: state_nxt = ST_WWAIT;
      ST_WWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_READ;
        end
      end
      ST_FDIV: state_nxt = ST_FWAIT;
      ST_FWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    px_nxt        = px_r;
    py_nxt        = py_r;
    n_nxt         = n_r;
    o_nxt         = o_r;
    k_nxt         = k_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    val_nxt       = val_r;
    w_nxt         = w_r;
    wsum_nxt      = wsum_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        px_nxt   = in_x;
        py_nxt   = in_y;
        n_nxt    = n_clip;
        o_nxt    = '0;
        k_nxt    = '0;
        w_nxt    = W_ONE;
        wsum_nxt = '0;
        sum_nxt  = '0;
      end
      ST_READ: begin
        k_nxt = k_r + 3'd1;
      end
      ST_MUL_BOT: top_nxt = VAL_W'(corner_r[0]) + lerp_part;
      ST_BOT:     bot_nxt = VAL_W'(corner_r[2]) + lerp_part;
      ST_VAL:     val_nxt = top_r + lerp_part;
      ST_ACC: begin
        sum_nxt  = sum_r + SUM_W'(prod_r);
        wsum_nxt = wsum_r + WSUM_W'(w_r);
      end
      ST_WWAIT: begin
        if (div_stat.done) begin
          if (div_quot[DIV_NUM_W-1:W_W] != '0) begin
            w_nxt = {W_W{1'b1}};
          end else begin
            w_nxt = div_quot[W_W-1:0];
          end
          o_nxt = o_r + OCT_W'(1);
          k_nxt = '0;
        end
      end
      ST_FWAIT: begin
        if (div_stat.done) begin
          if (sum_r[SUM_W-1]) begin
            if (div_quot > DIV_NUM_W'(32768)) begin
              res_nxt = 16'h8000;
            end else begin
              res_nxt = -div_quot[SEED_W-1:0];
            end
          end else begin
            if (div_quot > DIV_NUM_W'(32767)) begin
              res_nxt = 16'h7FFF;
            end else begin
              res_nxt = div_quot[SEED_W-1:0];
            end
          end
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    n_r        <= n_nxt;
    o_r        <= o_nxt;
    k_r        <= k_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    val_r      <= val_nxt;
    w_r        <= w_nxt;
    wsum_r     <= wsum_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= mul_a * mul_b;
    if (state_r == ST_READ && k_r != 3'd0) begin
      corner_r[2'(k_r - 3'd1)] <= ram_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks on the sequencer.
  `OVN_ASSERT_NEXT(a_eval_starts, in_acc && (in_tuser[0] == OP_EVAL), state_r == ST_READ, "evaluate did not start reading")
  `OVN_ASSERT_NOW(a_octave_range, state_r == ST_READ, (o_r < n_r) && (n_r <= MAX_OCT), "octave index out of range")
  `OVN_ASSERT_NOW(a_div_done_wait, div_stat.done, (state_r == ST_WWAIT) || (state_r == ST_FWAIT), "divider finished while not awaited")
  `OVN_ASSERT_NEXT(a_push_loads, (state_r == ST_PUSH) && (!out_valid_r || out_tready), out_valid_r && (state_r == ST_IDLE), "result not loaded into output register")

endmodule

@@ hdl/ovn_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: an optional write, with the old word at that address read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/ovn_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ovn_pkg for widths and the command and status structs.
module ovn_div
  import ovn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_cmd_t             cmd,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_stat_t            stat,
  output logic [DIV_NUM_W-1:0] quot
);

  logic [DIV_NUM_W-1:0] numq_r, numq_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh = {rem_r, numq_r[DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
  end

  // The numerator is loaded top aligned; quotient bits shift in from the bottom.
  always_comb begin
    numq_nxt = numq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      numq_nxt = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = cmd.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      numq_nxt = {numq_r[DIV_NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    numq_r <= numq_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = numq_r;

endmodule
